// ===== design/clni_pkg.sv =====
`timescale 1ns / 1ps

package clni_pkg;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_INIT   = 3'd1,
		OP_CMD    = 3'd2,
		OP_DATA   = 3'd3,
		OP_CURSOR = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_WAIT = 2'd0,
		KIND_NIB  = 2'd1,
		KIND_BYTE = 2'd2
	} entry_kind_t;

	localparam int STEP_W  = 5;
	localparam int PHASE_W = 3;
	localparam int WAIT_W  = 21;
	localparam int MS_W    = 6;
	localparam int TPM_W   = 16;
	localparam int PROD_W  = MS_W + TPM_W;

	localparam logic [STEP_W-1:0] STEP_IDLE       = 5'd0;
	localparam logic [STEP_W-1:0] STEP_INIT_FIRST = 5'd1;
	localparam logic [STEP_W-1:0] STEP_INIT_LAST  = 5'd10;
	localparam logic [STEP_W-1:0] STEP_SINGLE     = 5'd11;

	localparam logic [WAIT_W-1:0] WAIT_MAX  = '1;
	localparam logic [TPM_W-1:0]  TPM_RESET = 16'd1;

	// rs / en positions inside the 6-bit pin word, data in [3:0]
	localparam int PIN_EN = 4;
	localparam int PIN_RS = 5;

	typedef struct packed {
		entry_kind_t     kind;
		logic [7:0]      val;
		logic [MS_W-1:0] wait_ms;
	} entry_t;

	// init script; anything outside it is a single byte from the pending register
	function automatic entry_t script_entry(logic [STEP_W-1:0] step, logic [7:0] pending);
		entry_t e;
		case (step)
			5'd1:    e = '{KIND_WAIT, 8'h00, 6'd40};
			5'd2:    e = '{KIND_NIB,  8'h03, 6'd5};
			5'd3:    e = '{KIND_NIB,  8'h03, 6'd5};
			5'd4:    e = '{KIND_NIB,  8'h03, 6'd1};
			5'd5:    e = '{KIND_NIB,  8'h02, 6'd1};
			5'd6:    e = '{KIND_BYTE, 8'h28, 6'd2};
			5'd7:    e = '{KIND_BYTE, 8'h0C, 6'd2};
			5'd8:    e = '{KIND_BYTE, 8'h06, 6'd2};
			5'd9:    e = '{KIND_BYTE, 8'h01, 6'd2};
			5'd10:   e = '{KIND_WAIT, 8'h00, 6'd2};
			default: e = '{KIND_BYTE, pending, 6'd2};
		endcase
		return e;
	endfunction

	function automatic logic [PHASE_W-1:0] phase_count(entry_kind_t kind);
		logic [PHASE_W-1:0] n;
		case (kind)
			KIND_WAIT: n = 3'd1;
			KIND_NIB:  n = 3'd3;
			default:   n = 3'd5;
		endcase
		return n;
	endfunction

endpackage

// ===== design/char_lcd_nibble_interface.sv =====
`timescale 1ns / 1ps

// Character LCD controller for an HD44780-style panel on a 4-bit bus. Each input
// transaction is either a time tick or a request (init, command byte, data byte,
// set cursor). Time only moves on tick transactions; cfg_wr_data sets how many
// ticks make one millisecond (zero makes every phase one tick long, and phase
// lengths saturate at 2^21-1 ticks). A byte goes out high nibble first; each
// nibble is EN high 1 ms then EN low 1 ms, and each byte ends with a 2 ms gap.
// Init is 40 ms wait, nibbles 3,3,3,2, then 0x28, 0x0C, 0x06, 0x01 and 2 ms.
// Requests arriving while busy are refused (accepted = 0) and change nothing;
// opcodes 5..7 are ignored. Every input transaction yields exactly one output
// transaction with the pin levels after it. Throughput is one transaction per
// clock: the sequencer, the ms-to-ticks multiply (6x16) and the counter update
// are a single combinational pass into the state and output registers, and the
// input stays ready whenever the output register is empty or being drained.
// Write the tick rate only while the controller is idle.
module char_lcd_nibble_interface
	import clni_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config: ticks per millisecond
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] byte_value, [8] row, [14:9] column, [15] zero
	input  logic [2:0]  s_axis_tuser,  // [2:0] opcode
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] reg_select, [1] enable_pin, [5:2] data_nibble,
	                                   // [6] busy_res, [7] accepted
);

	// sequencer state
	logic [TPM_W-1:0]   tpm_q;
	logic [STEP_W-1:0]  step_q;
	logic [PHASE_W-1:0] phase_q;
	logic [WAIT_W-1:0]  wait_q;
	logic [7:0]         pend_q;
	logic [5:0]         pins_q;

	// output register
	logic               m_valid_q;
	logic [7:0]         m_data_q;

	// next-state terms
	logic [STEP_W-1:0]  step_n;
	logic [PHASE_W-1:0] phase_n;
	logic [PHASE_W-1:0] phase_inc;
	logic [WAIT_W-1:0]  wait_n;
	logic [7:0]         pend_sel;
	logic [7:0]         pend_n;
	logic [5:0]         pins_n;
	logic               acc_n;
	logic               do_enter;
	logic [MS_W-1:0]    ms_sel;
	logic [PROD_W-1:0]  wait_prod;
	entry_t             cur_e;
	entry_t             nxt_e;

	logic               in_xfer;
	logic               busy;
	opcode_t            op;
	logic [7:0]         in_byte;
	logic               in_row;
	logic [5:0]         in_col;
	logic [7:0]         cursor_addr;

	assign in_byte = s_axis_tdata[7:0];
	assign in_row  = s_axis_tdata[8];
	assign in_col  = s_axis_tdata[14:9];
	assign op      = opcode_t'(s_axis_tuser);

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign busy          = (step_q != STEP_IDLE);

	// row 1 starts at DDRAM 0x40; the sum wraps in 8 bits before the set-address bit
	assign cursor_addr = 8'h80 | ((in_row ? 8'h40 : 8'h00) + {2'b00, in_col});

	always_comb begin
		step_n    = step_q;
		phase_n   = phase_q;
		wait_n    = wait_q;
		pend_sel  = pend_q;
		pins_n    = pins_q;
		acc_n     = 1'b0;
		do_enter  = 1'b0;
		cur_e     = script_entry(step_q, pend_q);
		phase_inc = phase_q + 3'd1;

		case (op)
			OP_TICK: begin
				if (busy) begin
					if (wait_q > 21'd1) begin
						wait_n = wait_q - 21'd1;
					end else if (phase_inc >= phase_count(cur_e.kind)) begin
						phase_n = '0;
						if (step_q >= STEP_INIT_FIRST && step_q < STEP_INIT_LAST) begin
							step_n   = step_q + 5'd1;
							do_enter = 1'b1;
						end else begin
							step_n = STEP_IDLE;
							wait_n = '0;
						end
					end else begin
						phase_n  = phase_inc;
						do_enter = 1'b1;
					end
				end
			end
			OP_INIT, OP_CMD, OP_DATA, OP_CURSOR: begin
				if (!busy) begin
					acc_n          = 1'b1;
					pins_n[PIN_RS] = (op == OP_DATA);
					phase_n        = '0;
					do_enter       = 1'b1;
					if (op == OP_INIT) begin
						step_n = STEP_INIT_FIRST;
					end else begin
						step_n   = STEP_SINGLE;
						pend_sel = (op == OP_CURSOR) ? cursor_addr : in_byte;
					end
				end
			end
			default: ;
		endcase

		// init command bytes are loaded into the pending register on entry
		nxt_e  = script_entry(step_n, pend_sel);
		pend_n = (do_enter && nxt_e.kind == KIND_BYTE && step_n <= STEP_INIT_LAST)
		         ? nxt_e.val : pend_sel;

		// phase entry: pins and phase length in ms
		ms_sel = 6'd1;
		if (do_enter) begin
			case (nxt_e.kind)
				KIND_WAIT: ms_sel = nxt_e.wait_ms;
				KIND_NIB: begin
					case (phase_n)
						3'd0: begin
							pins_n[3:0]    = nxt_e.val[3:0];
							pins_n[PIN_EN] = 1'b1;
						end
						3'd1:    pins_n[PIN_EN] = 1'b0;
						default: ms_sel = nxt_e.wait_ms;
					endcase
				end
				default: begin
					case (phase_n)
						3'd0: begin
							pins_n[3:0]    = pend_n[7:4];
							pins_n[PIN_EN] = 1'b1;
						end
						3'd2: begin
							pins_n[3:0]    = pend_n[3:0];
							pins_n[PIN_EN] = 1'b1;
						end
						3'd1, 3'd3: pins_n[PIN_EN] = 1'b0;
						default:    ms_sel = nxt_e.wait_ms;
					endcase
				end
			endcase
		end

		wait_prod = {{TPM_W{1'b0}}, ms_sel} * {{MS_W{1'b0}}, tpm_q};
		if (do_enter) begin
			wait_n = (wait_prod > {1'b0, WAIT_MAX}) ? WAIT_MAX : wait_prod[WAIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q   <= TPM_RESET;
			step_q  <= STEP_IDLE;
			phase_q <= '0;
			wait_q  <= '0;
			pend_q  <= '0;
			pins_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				tpm_q <= cfg_wr_data;
			end
			if (in_xfer) begin
				step_q  <= step_n;
				phase_q <= phase_n;
				wait_q  <= wait_n;
				pend_q  <= pend_n;
				pins_q  <= pins_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_xfer) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_data_q <= {acc_n, (step_n != STEP_IDLE), pins_n[3:0], pins_n[PIN_EN],
			             pins_n[PIN_RS]};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
	// idle always means no pending wait
	a_idle_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_IDLE) |-> (wait_q == '0))
		else $error("wait counter nonzero while idle");

	// byte entries have five phases at most
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= 3'd4)
		else $error("nibble phase out of range");

	// a request while busy is refused
	a_busy_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && busy && op != OP_TICK) |=> !m_axis_tdata[7])
		else $error("request accepted while busy");

	// an accepted data request raises RS
	a_data_rs: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !busy && op == OP_DATA) |=> (pins_q[PIN_RS] && m_axis_tdata[0]))
		else $error("RS not high for data byte");
`endif

endmodule
